[hw/rtl/rrhl_pkg.sv]
// Package for the round-robin hand-off lock manager: request and result codes,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
package rrhl_pkg;

    // Request kinds.
    localparam logic [1:0] KIND_ACQUIRE = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_TRY     = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_GRANTED  = 2'd0;
    localparam logic [1:0] STAT_QUEUED   = 2'd1;
    localparam logic [1:0] STAT_REFUSED  = 2'd2;
    localparam logic [1:0] STAT_RELEASED = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FINISH
    } rrhl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // request accepted: capture it and start the count read
        logic eval;    // count data is back: update state and run the search
        logic finish;  // move the staged result into the response register
    } rrhl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_noop;  // the offered request has the unused kind
        logic rsp_busy;  // the response register holds a result not yet taken
    } rrhl_sts_t;

endpackage

[hw/rtl/rrhl_ctrl.sv]
// Controller state machine for the round-robin hand-off lock manager.
// Depends on rrhl_pkg.
module rrhl_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  rrhl_pkg::rrhl_sts_t sts,
    output rrhl_pkg::rrhl_cmd_t cmd
);
    import rrhl_pkg::*;

    rrhl_state_t state_reg;
    rrhl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && !sts.req_noop)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!sts.rsp_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        req_ready  = 1'b0;
        cmd.load   = 1'b0;
        cmd.eval   = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid && !sts.req_noop;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = !sts.rsp_busy;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/rrhl_dpath.sv]
// Datapath of the round-robin hand-off lock manager: waiter count memory, nonzero flags,
// in-use flag, cyclic hand-off search and the response register. Depends on rrhl_pkg.
module rrhl_dpath
#(
    parameter int SLOTS       = 64,
    parameter int MAX_WAITERS = 255
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rrhl_pkg::rrhl_cmd_t cmd,
    output rrhl_pkg::rrhl_sts_t sts,
    input  logic [1:0]          kind,
    input  logic [5:0]          slot,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [1:0]          status,
    output logic                grant_valid,
    output logic [5:0]          grant_slot
);
    import rrhl_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(MAX_WAITERS + 1);
    localparam int DW = 2 * SLOTS;

    // Waiter counts; an entry whose nonzero flag is clear reads as zero.
    logic [CW-1:0]    mem [SLOTS];
    logic [CW-1:0]    rd_reg;
    logic [SLOTS-1:0] nz_reg;
    logic             in_use_reg;

    // Captured request.
    logic [1:0]       kind_reg;
    logic [AW-1:0]    addr_reg;
    logic             ok_reg;

    // Staged result.
    logic [1:0]       stat_reg;
    logic             rel_reg;
    logic             found_reg;
    logic             own_reg;
    logic [SLOTS-1:0] hot_reg;

    // Response register.
    logic             rsp_valid_reg;
    logic [1:0]       status_reg;
    logic             grant_valid_reg;
    logic [5:0]       grant_slot_reg;

    logic [CW-1:0]    cur;
    logic [CW-1:0]    cnt_up;
    logic [CW-1:0]    cnt_dn;
    logic [SLOTS-1:0] others;
    logic [DW-1:0]    dbl;
    logic [DW-1:0]    base;
    logic [DW-1:0]    pick;
    logic [SLOTS-1:0] hot_next;
    logic [AW-1:0]    hot_idx;

    assign sts.req_noop = (kind == KIND_NONE);
    assign sts.rsp_busy = rsp_valid_reg && !rsp_ready;

    assign cur    = nz_reg[addr_reg] ? rd_reg : '0;
    assign cnt_up = (cur < CW'(MAX_WAITERS)) ? cur + CW'(1) : cur;
    assign cnt_dn = (cur != '0) ? cur - CW'(1) : cur;

    // First waiting slot after the releaser in cyclic order: the vector of other
    // waiting slots is doubled and the lowest set bit at or above slot+1 is isolated.
    always_comb
    begin
        others           = nz_reg;
        others[addr_reg] = 1'b0;
        dbl              = {others, others};
        base             = DW'(1) << (DW'(addr_reg) + DW'(1));
        pick             = dbl & ~(dbl - base);
        hot_next         = pick[SLOTS-1:0] | pick[DW-1:SLOTS];
    end

    // One-hot to index.
    always_comb
    begin
        hot_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (hot_reg[i])
            begin
                hot_idx = hot_idx | AW'(i);
            end
        end
    end

    // Count memory with registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_reg <= mem[AW'(slot)];
        end
        if (cmd.eval && ok_reg)
        begin
            if (kind_reg == KIND_ACQUIRE || (kind_reg == KIND_TRY && !in_use_reg))
            begin
                mem[addr_reg] <= cnt_up;
            end
            else if (kind_reg == KIND_RELEASE)
            begin
                mem[addr_reg] <= cnt_dn;
            end
        end
    end

    // Request capture and staged result (payload, no reset).
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            addr_reg <= AW'(slot);
            ok_reg   <= (32'(slot) < SLOTS);
        end
        if (cmd.eval)
        begin
            hot_reg   <= hot_next;
            found_reg <= (others != '0);
            own_reg   <= (cnt_dn != '0);
            rel_reg   <= ok_reg && (kind_reg == KIND_RELEASE);
            if (!ok_reg)
            begin
                stat_reg <= STAT_REFUSED;
            end
            else
            begin
                case (kind_reg)
                    KIND_ACQUIRE: stat_reg <= in_use_reg ? STAT_QUEUED : STAT_GRANTED;
                    KIND_TRY:     stat_reg <= in_use_reg ? STAT_REFUSED : STAT_GRANTED;
                    KIND_RELEASE: stat_reg <= STAT_RELEASED;
                    default:      stat_reg <= STAT_REFUSED;
                endcase
            end
        end
        if (cmd.finish)
        begin
            status_reg      <= stat_reg;
            grant_valid_reg <= rel_reg && (found_reg || own_reg);
            if (rel_reg && found_reg)
            begin
                grant_slot_reg <= 6'(hot_idx);
            end
            else if (rel_reg && own_reg)
            begin
                grant_slot_reg <= 6'(addr_reg);
            end
            else
            begin
                grant_slot_reg <= '0;
            end
        end
    end

    // Control state: nonzero flags, in-use flag, response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_reg        <= '0;
            in_use_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.eval && ok_reg)
            begin
                case (kind_reg)
                    KIND_ACQUIRE:
                    begin
                        nz_reg[addr_reg] <= 1'b1;
                        in_use_reg       <= 1'b1;
                    end
                    KIND_TRY:
                    begin
                        if (!in_use_reg)
                        begin
                            nz_reg[addr_reg] <= 1'b1;
                            in_use_reg       <= 1'b1;
                        end
                    end
                    KIND_RELEASE:
                    begin
                        nz_reg[addr_reg] <= (cnt_dn != '0);
                        in_use_reg       <= (others != '0) || (cnt_dn != '0);
                    end
                    default:
                    begin
                        in_use_reg <= in_use_reg;
                    end
                endcase
            end
            if (cmd.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign grant_valid = grant_valid_reg;
    assign grant_slot  = grant_slot_reg;

endmodule

[hw/rtl/round_robin_handoff_lock.sv]
// Top level of the round-robin hand-off lock manager.
// Depends on rrhl_pkg, rrhl_ctrl and rrhl_dpath.
//
// Usage:
// One lock shared by up to SLOTS requesters. Each request (kind, slot) on the
// req channel is an acquire, a release or a try-acquire; every request except
// the unused kind gives exactly one result (status, grant_valid, grant_slot) on
// the rsp channel. The unused kind is accepted and dropped with no result.
// A release that hands the lock on raises grant_valid and names the receiving
// slot: the next slot after the releaser, in cyclic order, that has waiters,
// or the releaser itself when only its own waiters remain.
// Timing: a request is taken in the idle cycle and its waiter count is read
// out of the count memory at that same edge. The update plus cyclic search
// over the per-slot nonzero flags runs in the next cycle and is staged, and
// the result enters the response register in the finish state, once that
// register is free. The block works on one request at a time: a new request
// is taken only in idle, after the last result has entered that register.
// A stalled receiver holds the result in the response register; a new request
// is still accepted and worked on, and waits only to enter that register.
// Reset clears the in-use flag and all nonzero flags, so every count reads as
// zero without a clearing pass; the block is ready right after reset.
module round_robin_handoff_lock
#(
    parameter int SLOTS       = 64,
    parameter int MAX_WAITERS = 255
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [1:0] kind,
    input  logic [5:0] slot,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output logic [1:0] status,
    output logic       grant_valid,
    output logic [5:0] grant_slot
);
    import rrhl_pkg::*;

    rrhl_cmd_t cmd;
    rrhl_sts_t sts;

    // Sequencing: idle, evaluate, finish.
    rrhl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Counts, flags, search and response register.
    rrhl_dpath
    #(
        .SLOTS       (SLOTS),
        .MAX_WAITERS (MAX_WAITERS)
    )
    u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .kind        (kind),
        .slot        (slot),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .grant_valid (grant_valid),
        .grant_slot  (grant_slot)
    );

endmodule

[hw/rtl/rrhl_checker.sv]
// Port-level checks for the round-robin hand-off lock manager, bound to the top level.
// Depends on rrhl_pkg and round_robin_handoff_lock.
module rrhl_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [1:0] kind,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] status,
    input logic       grant_valid,
    input logic [5:0] grant_slot
);
    import rrhl_pkg::*;

    // A hand-off only comes from a release.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && grant_valid |-> status == STAT_RELEASED)
    else $error("grant_valid on a result that is not a release");

    // Without a hand-off the grant slot is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !grant_valid |-> grant_slot == 6'd0)
    else $error("grant_slot nonzero without a hand-off");

    // The block works on one request at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && kind != KIND_NONE |=> !req_ready)
    else $error("request accepted while another is in progress");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(grant_valid) && $stable(grant_slot))
    else $error("result changed while stalled");

endmodule

bind round_robin_handoff_lock rrhl_checker u_rrhl_checker (.*);

[tb/sv/round_robin_handoff_lock_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the round-robin hand-off lock manager.
// Depends on rrhl_pkg and round_robin_handoff_lock, which needs rrhl_ctrl and rrhl_dpath.
module round_robin_handoff_lock_tb;

    import rrhl_pkg::*;

    // Build settings of the block under test. The slot port is 6 bits wide, so
    // every slot that can be driven is below NUM_SLOTS.
    localparam int NUM_SLOTS   = 64;
    localparam int MAX_WAITERS = 255;

    // One result of the lock manager, at the widths of the result ports.
    typedef struct packed {
        logic [1:0] status;
        logic       grant_valid;
        logic [5:0] grant_slot;
    } lock_rsp_t;

    // One row of the directed table. When hand_typed is set, the result in the
    // row is what the block must return; otherwise the predictor supplies it.
    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] slot;
        logic       hand_typed;
        lock_rsp_t  rsp;
    } lock_row_t;

    localparam lock_rsp_t NO_RSP = '0;
    localparam int DIRECTED_ROWS = 23;

    // The directed walk. It starts from reset, so the lock is free and every
    // count is zero. The rows cover an immediate grant, queueing behind the
    // holder, a refused try-acquire, a hand-off to the next slot in cyclic
    // order (with wrap-around), a hand-off back to the releaser's own waiters,
    // a release at a zero count while the lock is free, the unused kind and
    // both extreme slot numbers.
    lock_row_t directed_rows [DIRECTED_ROWS] = '{
        '{KIND_ACQUIRE,  6'd0, 1'b1, '{STAT_GRANTED,  1'b0, 6'd0}},
        '{KIND_ACQUIRE, 6'd63, 1'b1, '{STAT_QUEUED,   1'b0, 6'd0}},
        '{KIND_TRY,     6'd10, 1'b1, '{STAT_REFUSED,  1'b0, 6'd0}},
        '{KIND_ACQUIRE, 6'd63, 1'b0, NO_RSP},
        '{KIND_RELEASE,  6'd0, 1'b1, '{STAT_RELEASED, 1'b1, 6'd63}},
        '{KIND_NONE,    6'd21, 1'b0, NO_RSP},
        '{KIND_RELEASE, 6'd63, 1'b0, NO_RSP},
        '{KIND_RELEASE, 6'd63, 1'b1, '{STAT_RELEASED, 1'b0, 6'd0}},
        '{KIND_RELEASE, 6'd63, 1'b1, '{STAT_RELEASED, 1'b0, 6'd0}},
        '{KIND_TRY,     6'd42, 1'b1, '{STAT_GRANTED,  1'b0, 6'd0}},
        '{KIND_ACQUIRE, 6'd21, 1'b0, NO_RSP},
        '{KIND_ACQUIRE, 6'd42, 1'b0, NO_RSP},
        '{KIND_RELEASE, 6'd42, 1'b0, NO_RSP},
        '{KIND_RELEASE, 6'd21, 1'b0, NO_RSP},
        '{KIND_RELEASE, 6'd42, 1'b0, NO_RSP},
        '{KIND_TRY,     6'd63, 1'b1, '{STAT_GRANTED,  1'b0, 6'd0}},
        '{KIND_TRY,      6'd0, 1'b1, '{STAT_REFUSED,  1'b0, 6'd0}},
        '{KIND_RELEASE, 6'd63, 1'b1, '{STAT_RELEASED, 1'b0, 6'd0}},
        '{KIND_NONE,     6'd0, 1'b0, NO_RSP},
        '{KIND_ACQUIRE,  6'd1, 1'b0, NO_RSP},
        '{KIND_ACQUIRE, 6'd62, 1'b0, NO_RSP},
        '{KIND_RELEASE,  6'd1, 1'b0, NO_RSP},
        '{KIND_RELEASE, 6'd62, 1'b0, NO_RSP}
    };

    // Every input starts at a known value.
    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       req_valid   = 1'b0;
    logic [1:0] kind        = KIND_NONE;
    logic [5:0] slot        = 6'd0;
    logic       rsp_ready   = 1'b0;
    logic       req_ready;
    logic       rsp_valid;
    logic [1:0] status;
    logic       grant_valid;
    logic [5:0] grant_slot;

    // Predictor state: one waiter count per slot and the in-use flag.
    logic [7:0] waiter_counts [NUM_SLOTS];
    logic       lock_held;

    // Results still owed by the block, oldest first.
    lock_rsp_t  pending_rsps [$];
    int         error_count = 0;

    // Idle control. gap_pct is the chance that a request is preceded by a
    // burst of idle cycles; stall_pct is the chance per cycle that the
    // receiver starts a burst of stalls. Both are zero in quiet stretches.
    int         gap_pct     = 0;
    int         stall_pct   = 0;
    int         stall_left  = 0;

    // Hot slots for the random part: most requests go to a few neighbors so
    // that requesters actually contend and hand the lock around.
    logic [5:0] pool_base   = 6'd0;

    // Handshake flags and result fields sampled at the falling edge. Inputs
    // only change at the rising edge, so these equal the values that the
    // block sees at the next rising edge, without any race inside that step.
    logic       req_taken   = 1'b0;
    logic       rsp_taken   = 1'b0;
    lock_rsp_t  rsp_seen;

    round_robin_handoff_lock #(
        .SLOTS       (NUM_SLOTS),
        .MAX_WAITERS (MAX_WAITERS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .kind        (kind),
        .slot        (slot),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .grant_valid (grant_valid),
        .grant_slot  (grant_slot)
    );

    // 20 ns clock period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        req_taken = req_valid && req_ready;
        rsp_taken = rsp_valid && rsp_ready;
        rsp_seen  = '{status, grant_valid, grant_slot};
    end

    // Predictor. It applies one accepted request to the local copy of the
    // lock state and works out the result the block must return for it.
    task automatic apply_lock_request(input logic [1:0] req_kind, input logic [5:0] req_slot,
                                      output bit gives_rsp, output lock_rsp_t rsp);
        bit handed;
        int idx;
        rsp      = '0;
        gives_rsp = 1'b1;
        handed   = 1'b0;
        case (req_kind)
            KIND_ACQUIRE:
            begin
                // The count saturates at its maximum.
                if (waiter_counts[req_slot] != 8'(MAX_WAITERS))
                begin
                    waiter_counts[req_slot] = waiter_counts[req_slot] + 8'd1;
                end
                rsp.status = lock_held ? STAT_QUEUED : STAT_GRANTED;
                lock_held  = 1'b1;
            end
            KIND_TRY:
            begin
                // A refused try-acquire leaves the state alone. A granted one
                // also counts as a waiter so that its release balances.
                if (lock_held)
                begin
                    rsp.status = STAT_REFUSED;
                end
                else
                begin
                    lock_held = 1'b1;
                    if (waiter_counts[req_slot] != 8'(MAX_WAITERS))
                    begin
                        waiter_counts[req_slot] = waiter_counts[req_slot] + 8'd1;
                    end
                    rsp.status = STAT_GRANTED;
                end
            end
            KIND_RELEASE:
            begin
                // The count never goes below zero. The search starts at the
                // slot after the releaser and wraps around; the releaser's own
                // remaining waiters come last.
                if (waiter_counts[req_slot] != 8'd0)
                begin
                    waiter_counts[req_slot] = waiter_counts[req_slot] - 8'd1;
                end
                rsp.status = STAT_RELEASED;
                for (int i = 1; i < NUM_SLOTS && !handed; i++)
                begin
                    idx = (int'(req_slot) + i) % NUM_SLOTS;
                    if (waiter_counts[idx] != 8'd0)
                    begin
                        handed          = 1'b1;
                        rsp.grant_valid = 1'b1;
                        rsp.grant_slot  = 6'(idx);
                    end
                end
                if (!handed && waiter_counts[req_slot] != 8'd0)
                begin
                    handed          = 1'b1;
                    rsp.grant_valid = 1'b1;
                    rsp.grant_slot  = req_slot;
                end
                lock_held = handed;
            end
            default:
            begin
                // The unused kind is accepted and dropped without a result.
                gives_rsp = 1'b0;
            end
        endcase
    endtask

    // Offers one request and returns at the rising edge where it is taken.
    // valid stays high after that edge; the next call either presents a new
    // request in the same step or lowers valid for an idle burst.
    task automatic send_request(input logic [1:0] req_kind, input logic [5:0] req_slot,
                                input bit hand_typed, input lock_rsp_t typed_rsp);
        bit        gives_rsp;
        lock_rsp_t rsp;
        if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge clk);
        end
        req_valid <= 1'b1;
        kind      <= req_kind;
        slot      <= req_slot;
        do
        begin
            @(posedge clk);
        end
        while (!req_taken);
        apply_lock_request(req_kind, req_slot, gives_rsp, rsp);
        if (gives_rsp)
        begin
            pending_rsps.push_back(hand_typed ? typed_rsp : rsp);
        end
    endtask

    // Holds the request channel idle until every owed result has come back.
    // It never returns before a rising edge has passed, so valid is never
    // driven twice in the step where it returns.
    task automatic wait_for_results;
        req_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_rsps.size() != 0);
    endtask

    function automatic logic [5:0] pick_slot;
        if ($urandom_range(99, 0) < 65)
        begin
            return pool_base + 6'($urandom_range(3, 0));
        end
        return 6'($urandom_range(63, 0));
    endfunction

    // A slot that currently has waiters, found from a random starting point,
    // so that most releases come from a requester that really holds a place.
    function automatic logic [5:0] pick_waiting_slot;
        int start;
        int idx;
        start = $urandom_range(63, 0);
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            idx = (start + i) % NUM_SLOTS;
            if (waiter_counts[idx] != 8'd0)
            begin
                return 6'(idx);
            end
        end
        return pick_slot();
    endfunction

    // Sends one random request and tells whether it will give a result.
    // The mix is mostly acquires and well-matched releases; try-acquires,
    // releases from slots with nothing queued and the unused kind are noise.
    task automatic send_random_request(output bit counted);
        int         roll;
        logic [1:0] req_kind;
        logic [5:0] req_slot;
        roll = $urandom_range(99, 0);
        if (roll < 38)
        begin
            req_kind = KIND_ACQUIRE;
            req_slot = pick_slot();
        end
        else if (roll < 70)
        begin
            req_kind = KIND_RELEASE;
            req_slot = pick_waiting_slot();
        end
        else if (roll < 82)
        begin
            req_kind = KIND_TRY;
            req_slot = pick_slot();
        end
        else if (roll < 92)
        begin
            req_kind = KIND_RELEASE;
            req_slot = 6'($urandom_range(63, 0));
        end
        else
        begin
            req_kind = KIND_NONE;
            req_slot = 6'($urandom_range(63, 0));
        end
        counted = (req_kind != KIND_NONE);
        send_request(req_kind, req_slot, 1'b0, NO_RSP);
    endtask

    // Receiver: ready in general, with random bursts of stalls.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            rsp_ready <= 1'b0;
        end
        else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct)
        begin
            stall_left = $urandom_range(16, 1) - 1;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    // Checker: every result taken is compared, field by field, with the
    // oldest result still owed.
    always @(posedge clk)
    begin
        lock_rsp_t want;
        if (rsp_taken)
        begin
            if (pending_rsps.size() == 0)
            begin
                $display("%0t ns: result with none owed: status %0d grant_valid %0d grant_slot %0d",
                         $time, rsp_seen.status, rsp_seen.grant_valid, rsp_seen.grant_slot);
                error_count++;
            end
            else
            begin
                want = pending_rsps.pop_front();
                if (rsp_seen.status !== want.status)
                begin
                    $display("%0t ns: status mismatch: expected %0d actual %0d",
                             $time, want.status, rsp_seen.status);
                    error_count++;
                end
                if (rsp_seen.grant_valid !== want.grant_valid)
                begin
                    $display("%0t ns: grant_valid mismatch: expected %0d actual %0d",
                             $time, want.grant_valid, rsp_seen.grant_valid);
                    error_count++;
                end
                if (rsp_seen.grant_slot !== want.grant_slot)
                begin
                    $display("%0t ns: grant_slot mismatch: expected %0d actual %0d",
                             $time, want.grant_slot, rsp_seen.grant_slot);
                    error_count++;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int  counted_reqs;
        int  sat_slot;
        bit  counted;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            waiter_counts[i] = 8'd0;
        end
        lock_held = 1'b0;
        gap_pct   = 25;
        stall_pct = 6;

        // Reset is held, then released at a rising edge; the block needs no
        // clearing pass afterwards.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].kind, directed_rows[i].slot,
                         directed_rows[i].hand_typed, directed_rows[i].rsp);
        end

        // The sender pauses here until the block has answered everything.
        wait_for_results();

        // Random contention. Of every 180 counted requests the first 120 idle in
        // bursts and the last 60 run quiet, so that long stretches run back to back.
        counted_reqs = 0;
        while (counted_reqs < 380)
        begin
            if (counted_reqs % 40 == 0)
            begin
                pool_base = 6'($urandom_range(63, 0));
            end
            if ((counted_reqs / 60) % 3 == 2)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = 25;
                stall_pct = 8;
            end
            send_random_request(counted);
            if (counted)
            begin
                counted_reqs++;
            end
        end
        wait_for_results();

        // Count saturation: one slot gets more acquires than its count can
        // hold, then is released past zero. The later hand-offs and the final
        // freeing of the lock only come out right if the count stopped at its
        // maximum and never wrapped below zero.
        gap_pct   = 15;
        stall_pct = 5;
        sat_slot  = $urandom_range(63, 0);
        repeat (MAX_WAITERS + 7)
        begin
            send_request(KIND_ACQUIRE, 6'(sat_slot), 1'b0, NO_RSP);
        end
        repeat (MAX_WAITERS + 3)
        begin
            send_request(KIND_RELEASE, 6'(sat_slot), 1'b0, NO_RSP);
        end

        // Last part: random requests at full rate with no idling on either side.
        gap_pct   = 0;
        stall_pct = 0;
        counted_reqs = 0;
        while (counted_reqs < 150)
        begin
            if (counted_reqs % 40 == 0)
            begin
                pool_base = 6'($urandom_range(63, 0));
            end
            send_random_request(counted);
            if (counted)
            begin
                counted_reqs++;
            end
        end
        wait_for_results();

        // An idle stretch at the end catches any result the block should not have sent.
        repeat (20) @(posedge clk);
        if (error_count == 0 && pending_rsps.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0t ns: %0d mismatches, %0d results still owed",
                     $time, error_count, pending_rsps.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("%0t ns: timeout, %0d results still owed", $time, pending_rsps.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
